// ===== rtl/bra_pkg.sv =====
// ----------------------------------------------------------------------------
// bra_pkg
// shared constants for the beacon rssi aggregator
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int unsigned SAMPLES = 5;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [31:0] WRAP_HALF = 32'h8000_0000;

  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_FINISH  = 1'b1;
  localparam logic KIND_BEACON  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

endpackage

// ===== rtl/bra_divider.sv =====
// ----------------------------------------------------------------------------
// bra_divider
// shared signed restoring divider, one quotient bit a cycle, truncating
// ----------------------------------------------------------------------------
module bra_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [23:0] dividend,
  input  logic        [15:0] divisor,
  output logic               busy,
  output logic               done,
  output logic signed [7:0]  quotient
);
  logic [23:0] rem_r, rem_nxt;
  logic [23:0] quo_r, quo_nxt;
  logic [15:0] dsr_r;
  logic        neg_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, done_r;
  logic [24:0] trial;
  logic [23:0] mag;
  logic [23:0] qs;

  assign mag = dividend[23] ? (~dividend + 24'd1) : dividend;
  assign trial = {rem_r, quo_r[23]} - {9'd0, dsr_r};

  always_comb begin
    rem_nxt = {rem_r[22:0], quo_r[23]};
    quo_nxt = {quo_r[22:0], 1'b0};
    cnt_nxt = cnt_r - 5'd1;
    if (!trial[24]) begin
      rem_nxt = trial[23:0];
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd24;
        rem_r  <= '0;
        quo_r  <= mag;
        dsr_r  <= divisor;
        neg_r  <= dividend[23];
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_nxt;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign qs = neg_r ? (~quo_r + 24'd1) : quo_r;
  assign quotient = (dsr_r == 16'd0) ? 8'sd0 : qs[7:0];
  assign busy = busy_r;
  assign done = done_r;
endmodule

// ===== rtl/beacon_rssi_aggregator.sv =====
// ----------------------------------------------------------------------------
// beacon_rssi_aggregator
// per-scan beacon table with trimmed and plain rssi averages
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one item per observation (cmd 0) or a finish command (cmd 1).
//   a known observation walks the table one entry a cycle, then updates the
//   matching or new entry.
//   a finish with scan_ok set scores every entry through one shared sort and
//   divider (loading its samples, sorting a full set, dividing for the mean,
//   then scoring), then emits one out_* item per entry in creation order;
//   every finish ends with a summary item with tlast.
//   in_tready is low while an item is being worked on or output is pending.
//   when out_tready is low the pending item holds and the sequencer waits.
//   the sample store is a memory of TABLE_ENTRIES*5 entries, one port.
//   reset empties the table and clears the counters at once, no sweep.
// ----------------------------------------------------------------------------
module beacon_rssi_aggregator #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // identity, known, track_number, rssi, tx_power, seen_ms, scan_ok,
  // prior_dropped, pad
  input  logic [127:0] in_tdata,
  // cmd
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // identity_out, track_out, trimmed_rssi, mean_rssi, peak_rssi,
  // peak_tx_power, latest_ms, sample_total, is_best, dropped_total, pad
  output logic [159:0] out_tdata,
  // kind
  output logic         out_tuser,
  output logic         out_tlast
);
  import bra_pkg::*;

  localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int UW = $clog2(TABLE_ENTRIES + 1);
  localparam int SD = TABLE_ENTRIES * SAMPLES;
  localparam int SW = $clog2(SD);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SEARCH = 9'b000000010,
    S_UPDATE = 9'b000000100,
    S_LOAD   = 9'b000001000,
    S_SORT   = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_SCORE  = 9'b001000000,
    S_EMIT   = 9'b010000000,
    S_SUMM   = 9'b100000000
  } state_t;

  state_t state_r;

  // input fields
  logic               i_cmd, i_known, i_ok;
  logic        [47:0] i_id;
  logic        [7:0]  i_track;
  logic signed [7:0]  i_rssi, i_tx;
  logic        [31:0] i_seen;
  logic        [15:0] i_prior;
  assign i_cmd   = in_tuser;
  assign i_id    = in_tdata[47:0];
  assign i_known = in_tdata[48];
  assign i_track = in_tdata[56:49];
  assign i_rssi  = in_tdata[64:57];
  assign i_tx    = in_tdata[72:65];
  assign i_seen  = in_tdata[104:73];
  assign i_ok    = in_tdata[105];
  assign i_prior = in_tdata[121:106];

  // held item
  logic        [47:0] h_id_r;
  logic        [7:0]  h_track_r;
  logic signed [7:0]  h_rssi_r, h_tx_r;
  logic        [31:0] h_seen_r;
  logic               h_ok_r;
  logic        [15:0] h_prior_r;

  // entry table
  logic        [47:0] e_id    [TABLE_ENTRIES];
  logic        [7:0]  e_track [TABLE_ENTRIES];
  logic signed [23:0] e_sum   [TABLE_ENTRIES];
  logic        [15:0] e_cnt   [TABLE_ENTRIES];
  logic        [2:0]  e_kept  [TABLE_ENTRIES];
  logic signed [7:0]  e_peak  [TABLE_ENTRIES];
  logic signed [7:0]  e_ptx   [TABLE_ENTRIES];
  logic        [31:0] e_lat   [TABLE_ENTRIES];
  logic signed [7:0]  e_trim  [TABLE_ENTRIES];
  logic signed [7:0]  e_mean  [TABLE_ENTRIES];
  logic signed [7:0]  samp_mem [SD];

  logic [UW-1:0] used_r;
  logic [15:0]   raw_r, drops_r;
  logic [UW-1:0] idx_r;
  logic [EW-1:0] ix;
  logic [EW-1:0] best_r;
  logic signed [7:0] best_val_r;

  // finish work
  logic signed [7:0]  v_r [SAMPLES];
  logic [2:0]         ld_r;
  logic [3:0]         st_r;
  logic [SW-1:0]      rd_addr;
  logic signed [7:0]  rd_data_r;
  logic               rd_en;
  logic signed [23:0] div_a;
  logic [15:0]        div_b;
  logic               div_start, div_busy, div_done;
  logic signed [7:0]  div_q;

  logic [159:0] od_r;
  logic         ou_r, ol_r, ov_r;
  logic         out_load;

  assign ix = idx_r[EW-1:0];

  bra_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  // sort step schedule over pairs (i, j), i < j
  logic [2:0] pi, pj;
  always_comb begin
    case (st_r)
      4'd0: begin pi = 3'd0; pj = 3'd1; end
      4'd1: begin pi = 3'd0; pj = 3'd2; end
      4'd2: begin pi = 3'd0; pj = 3'd3; end
      4'd3: begin pi = 3'd0; pj = 3'd4; end
      4'd4: begin pi = 3'd1; pj = 3'd2; end
      4'd5: begin pi = 3'd1; pj = 3'd3; end
      4'd6: begin pi = 3'd1; pj = 3'd4; end
      4'd7: begin pi = 3'd2; pj = 3'd3; end
      4'd8: begin pi = 3'd2; pj = 3'd4; end
      4'd9: begin pi = 3'd3; pj = 3'd4; end
      default: begin pi = 3'd0; pj = 3'd1; end
    endcase
  end

  // trimmed dividend and divisor
  logic signed [23:0] tsum;
  logic [2:0]         tdiv;
  always_comb begin
    if (e_kept[ix] == 3'(SAMPLES)) begin
      tsum = 24'(v_r[1]) + 24'(v_r[2]) + 24'(v_r[3]);
      tdiv = 3'd3;
    end else begin
      tsum = 24'(v_r[0]) + 24'(v_r[1]) + 24'(v_r[2]) + 24'(v_r[3]);
      tdiv = e_kept[ix];
    end
  end

  // small divisors by shift, thirds by reciprocal multiply on the magnitude
  logic [9:0]        tmag, tq;
  logic [20:0]       tprod;
  logic signed [7:0] tval;
  always_comb begin
    tmag  = tsum[23] ? 10'(-tsum) : tsum[9:0];
    tprod = {11'd0, tmag} * 21'd683;
    case (tdiv)
      3'd1: tq = tmag;
      3'd2: tq = {1'b0, tmag[9:1]};
      3'd3: tq = tprod[20:11];
      3'd4: tq = {2'b0, tmag[9:2]};
      default: tq = '0;
    endcase
    tval = tsum[23] ? -(8'(tq)) : 8'(tq);
  end

  assign div_start = (state_r == S_SORT) && (st_r == 4'd10);
  assign div_a = e_sum[ix];
  assign div_b = e_cnt[ix];

  assign rd_en   = (state_r == S_LOAD) && (ld_r < 3'(SAMPLES));
  assign rd_addr = SW'(int'(ix) * SAMPLES + int'(ld_r));

  logic        hit;
  logic [SW-1:0] wr_addr;
  assign hit = (e_id[ix] == h_id_r);
  assign wr_addr = SW'(int'(ix) * SAMPLES + int'(e_kept[ix]));

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= samp_mem[rd_addr];
    if (state_r == S_UPDATE && e_kept[ix] < 3'(SAMPLES)) samp_mem[wr_addr] <= h_rssi_r;
  end

  logic [16:0] dsum;
  logic [15:0] sdrop;
  assign dsum = {1'b0, h_prior_r} + {1'b0, drops_r};
  assign sdrop = !h_ok_r ? h_prior_r : (dsum[16] ? COUNT_MAX : dsum[15:0]);

  assign out_load = (state_r == S_EMIT || state_r == S_SUMM) && (!ov_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      raw_r   <= '0;
      drops_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (out_load) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            h_id_r <= i_id; h_track_r <= i_track; h_rssi_r <= i_rssi;
            h_tx_r <= i_tx; h_seen_r <= i_seen; h_ok_r <= i_ok;
            h_prior_r <= i_prior;
            idx_r <= '0;
            ld_r <= '0;
            if (i_cmd == CMD_FINISH) begin
              state_r <= (i_ok && used_r != '0) ? S_LOAD : S_SUMM;
            end else begin
              if (raw_r != COUNT_MAX) raw_r <= raw_r + 16'd1;
              if (i_known) state_r <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (idx_r == used_r) begin
            if (used_r == UW'(TABLE_ENTRIES)) begin
              if (drops_r != COUNT_MAX) drops_r <= drops_r + 16'd1;
              state_r <= S_IDLE;
            end else begin
              e_id[ix] <= h_id_r; e_track[ix] <= h_track_r;
              e_sum[ix] <= '0; e_cnt[ix] <= '0; e_kept[ix] <= '0;
              e_peak[ix] <= h_rssi_r; e_ptx[ix] <= h_tx_r; e_lat[ix] <= h_seen_r;
              used_r <= used_r + UW'(1);
              state_r <= S_UPDATE;
            end
          end else if (hit) begin
            state_r <= S_UPDATE;
          end else begin
            idx_r <= idx_r + UW'(1);
          end
        end
        S_UPDATE: begin
          if (e_cnt[ix] != COUNT_MAX) begin
            e_cnt[ix] <= e_cnt[ix] + 16'd1;
            e_sum[ix] <= e_sum[ix] + 24'(h_rssi_r);
          end
          if (e_kept[ix] < 3'(SAMPLES)) e_kept[ix] <= e_kept[ix] + 3'd1;
          if (h_rssi_r > e_peak[ix]) begin
            e_peak[ix] <= h_rssi_r;
            e_ptx[ix] <= h_tx_r;
          end
          if ((h_seen_r - e_lat[ix]) < WRAP_HALF) e_lat[ix] <= h_seen_r;
          state_r <= S_IDLE;
        end
        S_LOAD: begin
          // read data is registered, so it lands in the cycle after its address
          if (ld_r != 3'd0) begin
            v_r[ld_r - 3'd1] <= (ld_r - 3'd1 < e_kept[ix]) ? rd_data_r : 8'sd0;
          end
          if (ld_r == 3'(SAMPLES)) begin
            st_r <= (e_kept[ix] == 3'(SAMPLES)) ? 4'd0 : 4'd10;
            state_r <= S_SORT;
          end else begin
            ld_r <= ld_r + 3'd1;
          end
        end
        S_SORT: begin
          if (st_r == 4'd10) begin
            e_trim[ix] <= tval;
            state_r <= S_DIV;
          end else begin
            if (v_r[pi] > v_r[pj]) begin
              v_r[pi] <= v_r[pj];
              v_r[pj] <= v_r[pi];
            end
            st_r <= st_r + 4'd1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            e_mean[ix] <= div_q;
            state_r <= S_SCORE;
          end
        end
        S_SCORE: begin
          if (idx_r == '0 || e_trim[ix] > best_val_r) begin
            best_r <= ix;
            best_val_r <= e_trim[ix];
          end
          ld_r <= '0;
          if (idx_r + UW'(1) == used_r) begin
            idx_r <= '0;
            state_r <= S_EMIT;
          end else begin
            idx_r <= idx_r + UW'(1);
            state_r <= S_LOAD;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            od_r <= {7'd0, 16'd0, (ix == best_r), e_cnt[ix], e_lat[ix], e_ptx[ix],
                     e_peak[ix], e_mean[ix], e_trim[ix], e_track[ix], e_id[ix]};
            ou_r <= KIND_BEACON;
            ol_r <= 1'b0;
            if (idx_r + UW'(1) == used_r) state_r <= S_SUMM;
            else idx_r <= idx_r + UW'(1);
          end
        end
        S_SUMM: begin
          if (out_load) begin
            od_r <= {7'd0, sdrop, 1'b0, raw_r, 120'd0};
            ou_r <= KIND_SUMMARY;
            ol_r <= 1'b1;
            used_r <= '0;
            raw_r <= '0;
            drops_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(TABLE_ENTRIES)) else $error("table overfilled");
  a_last_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == out_tuser)) else $error("tlast not on summary");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
endmodule

// ===== bench/beacon_rssi_aggregator_tb.sv =====
// ----------------------------------------------------------------------------
// beacon_rssi_aggregator_tb
// self-checking bench: scans of beacon observations with random content and
// random idling on both sides; a local scan table predicts every beacon and
// summary item, which is checked field by field as it leaves the block
// ----------------------------------------------------------------------------
module beacon_rssi_aggregator_tb;
  import bra_pkg::*;

  localparam int TE = 8;
  localparam int LIMIT = 600000;

  typedef struct {
    logic        cmd;
    logic [47:0] id;
    logic        known;
    logic [7:0]  track;
    logic [7:0]  rssi;
    logic [7:0]  tx;
    logic [31:0] seen;
    logic        ok;
    logic [15:0] pd;
    bit          hold;
  } obs_t;

  typedef struct {
    logic        kind;
    logic [47:0] id;
    logic [7:0]  track;
    logic [7:0]  trimmed;
    logic [7:0]  mean;
    logic [7:0]  peak;
    logic [7:0]  peak_tx;
    logic [31:0] latest;
    logic [15:0] total;
    logic        best;
    logic [15:0] dropped;
    logic        last;
  } report_t;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tuser = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [159:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  beacon_rssi_aggregator #(.TABLE_ENTRIES(TE)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial forever #5 clk = ~clk;

  // scan table copy
  logic [47:0] tab_id [TE];
  logic [7:0]  tab_track [TE];
  int          tab_sum [TE];
  int          tab_count [TE];
  int          tab_kept [TE];
  int          tab_smp [TE][5];
  int          tab_peak [TE];
  logic [7:0]  tab_peak_tx [TE];
  logic [31:0] tab_latest [TE];
  int          used, raw_seen, table_drops;

  obs_t    pending_obs [$];
  report_t reports_due [$];
  obs_t    cur;
  bit      fired = 0;
  int      gap = 0, ogap = 0, burst = 0;
  int      cycles = 0, errors = 0, n_in = 0, n_out = 0, n_scans = 0, n_summ = 0;

  function automatic logic [127:0] pack_obs(obs_t o);
    return {6'b0, o.pd, o.ok, o.seen, o.tx, o.rssi, o.track, o.known, o.id};
  endfunction

  function automatic int trimmed_of(int e);
    int v[5];
    int t, acc;
    acc = 0;
    if (tab_kept[e] == 0) return 0;
    if (tab_kept[e] < 5) begin
      for (int i = 0; i < tab_kept[e]; i++) acc += tab_smp[e][i];
      return acc / tab_kept[e];
    end
    for (int i = 0; i < 5; i++) v[i] = tab_smp[e][i];
    for (int i = 0; i < 4; i++)
      for (int j = i + 1; j < 5; j++)
        if (v[i] > v[j]) begin
          t = v[i]; v[i] = v[j]; v[j] = t;
        end
    return (v[1] + v[2] + v[3]) / 3;
  endfunction

  task automatic observe(obs_t o);
    int e, r;
    r = $signed(o.rssi);
    if (raw_seen < 65535) raw_seen++;
    if (!o.known) return;
    for (e = 0; e < used; e++) if (tab_id[e] == o.id) break;
    if (e == used) begin
      if (used >= TE) begin
        if (table_drops < 65535) table_drops++;
        return;
      end
      tab_id[e] = o.id; tab_track[e] = o.track; tab_sum[e] = 0; tab_count[e] = 0;
      tab_kept[e] = 0; tab_peak[e] = r; tab_peak_tx[e] = o.tx; tab_latest[e] = o.seen;
      used++;
    end
    if (tab_count[e] < 65535) begin
      tab_count[e]++;
      tab_sum[e] += r;
    end
    if (tab_kept[e] < 5) begin
      tab_smp[e][tab_kept[e]] = r;
      tab_kept[e]++;
    end
    if (r > tab_peak[e]) begin
      tab_peak[e] = r;
      tab_peak_tx[e] = o.tx;
    end
    if (32'(o.seen - tab_latest[e]) < WRAP_HALF) tab_latest[e] = o.seen;
  endtask

  task automatic finish_scan(obs_t o);
    report_t r;
    int best, best_val, tr, drop;
    best = 0; best_val = 0; drop = int'(o.pd);
    if (o.ok) begin
      for (int e = 0; e < used; e++) begin
        tr = trimmed_of(e);
        if (e == 0 || tr > best_val) begin
          best = e; best_val = tr;
        end
      end
      for (int e = 0; e < used; e++) begin
        r = '{default: '0};
        r.kind = KIND_BEACON; r.id = tab_id[e]; r.track = tab_track[e];
        r.trimmed = 8'(trimmed_of(e)); r.mean = 8'(tab_sum[e] / tab_count[e]);
        r.peak = 8'(tab_peak[e]); r.peak_tx = tab_peak_tx[e]; r.latest = tab_latest[e];
        r.total = 16'(tab_count[e]); r.best = (e == best);
        reports_due.push_back(r);
      end
      drop += table_drops;
      if (drop > 65535) drop = 65535;
    end
    r = '{default: '0};
    r.kind = KIND_SUMMARY; r.total = 16'(raw_seen); r.dropped = 16'(drop); r.last = 1;
    reports_due.push_back(r);
    used = 0; raw_seen = 0; table_drops = 0;
  endtask

  task automatic cmp(string f, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: item %0d field %s expected %h actual %h", $time, n_out, f, e, a);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      report_t x;
      logic [159:0] d;
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
      end
      if (in_tvalid && in_tready) begin
        fired = 1;
        n_in++;
        if (cur.cmd == CMD_FINISH) begin
          finish_scan(cur);
          n_scans++;
        end else observe(cur);
      end
      if (out_tvalid && out_tready) begin
        d = out_tdata;
        ogap = burst ? 0 : $urandom_range(0, 5);
        if (reports_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual %h", $time, out_tdata);
        end else begin
          x = reports_due.pop_front();
          cmp("kind", x.kind, out_tuser);
          cmp("identity_out", x.id, d[47:0]);
          cmp("track_out", x.track, d[55:48]);
          cmp("trimmed_rssi", x.trimmed, d[63:56]);
          cmp("mean_rssi", x.mean, d[71:64]);
          cmp("peak_rssi", x.peak, d[79:72]);
          cmp("peak_tx_power", x.peak_tx, d[87:80]);
          cmp("latest_ms", x.latest, d[119:88]);
          cmp("sample_total", x.total, d[135:120]);
          cmp("is_best", x.best, d[136]);
          cmp("dropped_total", x.dropped, d[152:137]);
          cmp("last", x.last, out_tlast);
          if (x.kind == KIND_SUMMARY) n_summ++;
        end
        n_out++;
      end
    end
  end

  // item driver
  always @(negedge clk) begin
    logic v;
    if (rst_n) begin
      v = in_tvalid;
      if (fired) begin
        v = 0;
        fired = 0;
      end
      if (!v) begin
        if (gap > 0) gap--;
        else if (pending_obs.size() > 0 &&
                 !(pending_obs[0].hold && reports_due.size() > 0)) begin
          cur = pending_obs.pop_front();
          in_tdata <= pack_obs(cur);
          in_tuser <= cur.cmd;
          v = 1;
          if (n_in % 60 == 0) burst = ($urandom_range(0, 2) == 0);
          gap = burst ? 0 : $urandom_range(0, 5);
        end
      end
      in_tvalid <= v;
      if (ogap > 0) begin
        ogap--;
        out_tready <= 0;
      end else out_tready <= 1;
    end
  end

  function automatic obs_t mk(logic [47:0] id, logic known, logic [7:0] rssi,
                              logic [7:0] tx, logic [31:0] seen);
    obs_t o;
    o.cmd = CMD_OBSERVE; o.id = id; o.known = known; o.track = id[7:0] ^ 8'hA5;
    o.rssi = rssi; o.tx = tx; o.seen = seen; o.ok = 0; o.pd = 0; o.hold = 0;
    return o;
  endfunction

  function automatic obs_t mk_fin(logic ok, logic [15:0] pd);
    obs_t o;
    o = mk(48'({$urandom, $urandom}), 1'($urandom), 8'($urandom), 8'($urandom),
           32'($urandom));
    o.cmd = CMD_FINISH; o.ok = ok; o.pd = pd;
    return o;
  endfunction

  initial begin
    logic [47:0] pool [12];
    logic [31:0] base;
    obs_t o;
    int cnt, len;
    used = 0; raw_seen = 0; table_drops = 0;

    // wrap-aware time, peak ties, sample overflow, extreme identities
    pending_obs.push_back(mk(48'h1234_5678_9ABC, 1, 8'h80, 8'h7F, 32'hFFFF_FFF0));
    pending_obs.push_back(mk(48'h1234_5678_9ABC, 1, 8'h7F, 8'h80, 32'd10));
    pending_obs.push_back(mk(48'h1234_5678_9ABC, 1, 8'h7F, 8'h05, 32'h8000_0010));
    pending_obs.push_back(mk(48'h1234_5678_9ABC, 1, 8'hF0, 8'h00, 32'd5));
    pending_obs.push_back(mk(48'h1234_5678_9ABC, 1, 8'h01, 8'h00, 32'd11));
    pending_obs.push_back(mk(48'h1234_5678_9ABC, 1, 8'h80, 8'h00, 32'd12));
    pending_obs.push_back(mk(48'h0, 1, 8'h80, 8'h80, 32'h0));
    pending_obs.push_back(mk(48'hFFFF_FFFF_FFFF, 1, 8'h7F, 8'h7F, 32'hFFFF_FFFF));
    pending_obs.push_back(mk(48'hFFFF_FFFF_FFFF, 1, 8'hFF, 8'h7F, 32'h7FFF_FFFE));
    pending_obs.push_back(mk(48'h5555_AAAA_5555, 0, 8'h40, 8'h40, 32'd100));
    pending_obs.push_back(mk_fin(1, 16'd0));
    // full table, drops added to a saturated prior count
    for (int i = 0; i < 10; i++)
      pending_obs.push_back(mk(48'h100 + 48'(i), 1, 8'($urandom), 8'($urandom), 32'(i)));
    pending_obs.push_back(mk_fin(1, 16'hFFFF));
    // bad scan, then an empty good scan
    pending_obs.push_back(mk(48'h77, 1, 8'h10, 8'h10, 32'd1));
    pending_obs.push_back(mk_fin(0, 16'hFFFE));
    pending_obs.push_back(mk_fin(1, 16'h8001));

    cnt = pending_obs.size();
    while (cnt < 470) begin
      foreach (pool[i]) pool[i] = 48'({$urandom, $urandom});
      base = $urandom;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          o = mk(48'({$urandom, $urandom}), 1'($urandom), 8'($urandom), 8'($urandom),
                 32'($urandom));
          o.track = 8'($urandom); o.ok = 1'($urandom); o.pd = 16'($urandom);
        end else begin
          o = mk(pool[$urandom_range(0, 11)], $urandom_range(0, 9) != 0,
                 8'($urandom), 8'($urandom), base + $urandom_range(0, 4000) - 32'd2000);
          o.track = 8'($urandom);
        end
        pending_obs.push_back(o);
        cnt++;
      end
      o = mk_fin($urandom_range(0, 6) != 0,
                 ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9)));
      o.hold = (cnt > 200 && cnt < 240);
      pending_obs.push_back(o);
      cnt++;
    end
    pending_obs.push_back(mk_fin(1, 16'd3));

    repeat (4) @(posedge clk);
    rst_n <= 1;
    wait (pending_obs.size() == 0 && !in_tvalid);
    wait (reports_due.size() == 0);
    repeat (800) @(posedge clk);
    $display("%0d items sent over %0d scans, %0d results checked (%0d summaries)",
             n_in, n_scans, n_out, n_summ);
    if (errors == 0 && reports_due.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bra_pkg.sv
rtl/bra_divider.sv
rtl/beacon_rssi_aggregator.sv
bench/beacon_rssi_aggregator_tb.sv
